FILE: sv/krt_pkg.sv
// Shared types and constants for the keyed register table.
// No dependencies; the top level and krt_cell import this package.
package krt_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_READ_INPUT   = 8'd4;

  typedef enum logic [1:0] {
    KIND_WR16 = 2'd0,
    KIND_WR32 = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } krt_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FUNC  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } krt_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_WALK,
    S_DONE
  } krt_state_t;

  // Lookup token that travels down the cell chain, one cell per cycle.
  typedef struct packed {
    logic        live;
    logic        done;     // some cell has claimed this word
    logic        found;    // read: key present and not expired
    logic        is_read;
    logic [31:0] key;
    logic [15:0] value;    // write data going in, read data coming out
    logic [31:0] expiry;
    logic [31:0] now;
  } krt_tok_t;

endpackage

FILE: sv/krt_if.sv
// Handshake interfaces for the request and result channels.
// Depends on nothing but the field widths of the table block.
interface krt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  unit;
  logic [7:0]  function_code;
  logic [15:0] reg_address;
  logic [31:0] write_value;
  logic [15:0] max_age_ms;
  logic [31:0] now_ms;

  modport source (output valid, kind, unit, function_code, reg_address, write_value,
                  max_age_ms, now_ms, input ready);
  modport sink   (input valid, kind, unit, function_code, reg_address, write_value,
                  max_age_ms, now_ms, output ready);
endinterface

interface krt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] read_value;

  modport source (output valid, status, read_value, input ready);
  modport sink   (input valid, status, read_value, output ready);
endinterface

FILE: sv/keyed_register_table_with_expiry.sv
// channel | dir | word                                          | handshake
// in_ch   | in  | kind unit function_code reg_address           | valid/ready
//         |     | write_value max_age_ms now_ms                 |
// out_ch  | out | status read_value                             | valid/ready
//
// One request at a time. A lookup token walks the chain of TABLE_ENTRIES
// slot cells, one cell per cycle, so read and write16 results go valid
// after one walk and write32 results after two, low word then high word.
// Bad-function reads and the unused kind skip the walk (IDLE to DONE).
// in_ch.ready returns the cycle after the result word is loaded.
// Reset clears all slot valid bits directly; no clearing pass.
// A new request is taken while the previous result waits in out_ch.
// Top level of the keyed register table; depends on krt_pkg, krt_if, krt_cell.
module keyed_register_table_with_expiry
  import krt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  krt_in_if.sink     in_ch,
  krt_out_if.source  out_ch
);

  krt_state_t  state_r, state_nxt;
  krt_kind_t   kind_r, kind_nxt;
  logic [7:0]  unit_r, unit_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [31:0] wval_r, wval_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic [31:0] now_r, now_nxt;
  logic        phase_r, phase_nxt;   // write32: 0 low word, 1 high word
  logic        full_r, full_nxt;
  krt_status_t res_status_r, res_status_nxt;
  logic [15:0] res_val_r, res_val_nxt;
  logic        out_valid_r, out_valid_nxt;
  krt_status_t out_status_r, out_status_nxt;
  logic [15:0] out_val_r, out_val_nxt;

  logic        in_ready;
  logic        launch;
  logic        out_free;
  krt_tok_t    chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES:0] chain_live;
  krt_tok_t    tail;

  assign tail = chain[TABLE_ENTRIES];

  always_comb begin
    chain[0].live    = launch;
    chain[0].done    = 1'b0;
    chain[0].found   = 1'b0;
    chain[0].is_read = (kind_r == KIND_READ);
    chain[0].key     = {unit_r, func_r, phase_r ? addr_r + 16'd1 : addr_r};
    chain[0].value   = (kind_r == KIND_READ) ? 16'd0 :
                       (phase_r ? wval_r[31:16] : wval_r[15:0]);
    chain[0].expiry  = exp_r;
    chain[0].now     = now_r;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    krt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  for (genvar g = 0; g <= TABLE_ENTRIES; g++) begin : g_live
    assign chain_live[g] = chain[g].live;
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    unit_nxt       = unit_r;
    func_nxt       = func_r;
    addr_nxt       = addr_r;
    wval_nxt       = wval_r;
    exp_nxt        = exp_r;
    now_nxt        = now_r;
    phase_nxt      = phase_r;
    full_nxt       = full_r;
    res_status_nxt = res_status_r;
    res_val_nxt    = res_val_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_val_nxt    = out_val_r;
    in_ready       = 1'b0;
    launch         = 1'b0;
    out_free       = !out_valid_r || out_ch.ready;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          kind_nxt  = krt_kind_t'(in_ch.kind);
          unit_nxt  = in_ch.unit;
          func_nxt  = in_ch.function_code;
          addr_nxt  = in_ch.reg_address;
          wval_nxt  = in_ch.write_value;
          now_nxt   = in_ch.now_ms;
          exp_nxt   = (in_ch.max_age_ms == 16'd0) ? 32'd0 :
                      in_ch.now_ms + {16'd0, in_ch.max_age_ms};
          phase_nxt = 1'b0;
          full_nxt  = 1'b0;
          res_val_nxt = 16'd0;
          unique case (krt_kind_t'(in_ch.kind))
            KIND_WR16, KIND_WR32: begin
              state_nxt = S_LAUNCH;
            end
            KIND_READ: begin
              if (in_ch.function_code != FC_READ_HOLDING &&
                  in_ch.function_code != FC_READ_INPUT) begin
                res_status_nxt = ST_BAD_FUNC;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_LAUNCH;
              end
            end
            KIND_NONE: begin
              res_status_nxt = ST_OK;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_LAUNCH: begin
        launch    = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (tail.live) begin
          if (kind_r == KIND_READ) begin
            res_status_nxt = tail.found ? ST_OK : ST_NOT_FOUND;
            res_val_nxt    = tail.found ? tail.value : 16'd0;
            state_nxt      = S_DONE;
          end else if (kind_r == KIND_WR32 && !phase_r) begin
            full_nxt  = !tail.done;
            phase_nxt = 1'b1;
            state_nxt = S_LAUNCH;
          end else begin
            res_status_nxt = (full_r || !tail.done) ? ST_FULL : ST_OK;
            res_val_nxt    = 16'd0;
            state_nxt      = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_val_nxt    = res_val_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    unit_r       <= unit_nxt;
    func_r       <= func_nxt;
    addr_r       <= addr_nxt;
    wval_r       <= wval_nxt;
    exp_r        <= exp_nxt;
    now_r        <= now_nxt;
    phase_r      <= phase_nxt;
    full_r       <= full_nxt;
    res_status_r <= res_status_nxt;
    res_val_r    <= res_val_nxt;
    out_status_r <= out_status_nxt;
    out_val_r    <= out_val_nxt;
  end

  // no word is taken while reset is held
  assign in_ch.ready       = in_ready && rst_n;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.read_value = out_val_r;

`ifndef ASSERT_OFF
  // never more than one lookup in flight along the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_live))
    else $error("more than one token in the cell chain");

  a_tail_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tail.live |-> state_r == S_WALK)
    else $error("token left the chain outside of a walk");

  a_launch_empty: assert property (@(posedge clk) disable iff (!rst_n)
    launch |-> chain_live[TABLE_ENTRIES:1] == '0)
    else $error("token launched while chain busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r != S_IDLE)
    else $error("accepted word did not start work");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.read_value == 16'd0)
    else $error("nonzero read value on failed request");
`endif

endmodule

FILE: sv/krt_cell.sv
// One table slot plus the token register that passes lookups to the next slot.
// Depends on krt_pkg.
module krt_cell
  import krt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  krt_tok_t tok_i,
  output krt_tok_t tok_o
);

  logic        ent_valid_r, ent_valid_nxt;
  logic [31:0] ent_key_r, ent_key_nxt;
  logic [15:0] ent_val_r, ent_val_nxt;
  logic [31:0] ent_exp_r, ent_exp_nxt;
  logic        tok_live_r;
  krt_tok_t    tok_r, tok_nxt;
  logic        alive;
  logic        hit;
  logic        fresh;

  always_comb begin
    ent_valid_nxt = ent_valid_r;
    ent_key_nxt   = ent_key_r;
    ent_val_nxt   = ent_val_r;
    ent_exp_nxt   = ent_exp_r;
    tok_nxt       = tok_i;
    alive = tok_i.live && !tok_i.done;
    hit   = ent_valid_r && (ent_key_r == tok_i.key);
    fresh = !ent_valid_r;
    // slots fill from the low end and are never freed, so the first empty
    // slot means the key is absent further down the chain
    if (alive && hit) begin
      tok_nxt.done = 1'b1;
      if (tok_i.is_read) begin
        tok_nxt.found = (ent_exp_r == 32'd0) || (ent_exp_r > tok_i.now);
        tok_nxt.value = tok_nxt.found ? ent_val_r : 16'd0;
      end else begin
        ent_val_nxt = tok_i.value;
        ent_exp_nxt = tok_i.expiry;
      end
    end else if (alive && fresh) begin
      tok_nxt.done = 1'b1;
      if (!tok_i.is_read) begin
        ent_valid_nxt = 1'b1;
        ent_key_nxt   = tok_i.key;
        ent_val_nxt   = tok_i.value;
        ent_exp_nxt   = tok_i.expiry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
      tok_live_r  <= 1'b0;
    end else begin
      ent_valid_r <= ent_valid_nxt;
      tok_live_r  <= tok_nxt.live;
    end
  end

  always_ff @(posedge clk) begin
    ent_key_r <= ent_key_nxt;
    ent_val_r <= ent_val_nxt;
    ent_exp_r <= ent_exp_nxt;
    tok_r     <= tok_nxt;
  end

  always_comb begin
    tok_o      = tok_r;
    tok_o.live = tok_live_r;
  end

endmodule
